### design/tphr_pkg.sv
// ----------------------------------------------------------------------------
// Threshold peak heart rate package
// Widths, limits and register indexes shared by the heart rate estimator.
// ----------------------------------------------------------------------------
package tphr_pkg;

   // Most region peaks that take part in one record.
   localparam int MAX_PEAKS = 32;

   // Field widths.
   localparam int SAMPLE_W = 16;
   localparam int TICK_W   = 32;
   localparam int TMS_W    = 10;
   localparam int BPM_W    = 10;
   localparam int PEAK_W   = $clog2(MAX_PEAKS + 1);

   // Milliseconds in one minute, and the result ceiling.
   localparam int MS_W = 16;
   localparam logic [MS_W-1:0]  MS_PER_MINUTE = 16'd60000;
   localparam logic [BPM_W-1:0] BPM_LIMIT     = 10'd1023;

   // Divider widths: numerator is 60000 * (peaks - 1), divisor is span * tick_ms.
   localparam int NUM_W  = MS_W + PEAK_W;
   localparam int DEN_W  = TICK_W + TMS_W;
   localparam int STEP_W = $clog2(NUM_W);

   // Configuration port.
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = SAMPLE_W;
   localparam logic [CSR_ADDR_W-1:0] REG_THRESHOLD = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_TICK_MS   = 1'd1;

   // Reset values of the registers.
   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 16'd32768;
   localparam logic [TMS_W-1:0]    TICK_MS_RESET   = 10'd10;

endpackage

### design/threshold_peak_heart_rate.sv
// ----------------------------------------------------------------------------
// Threshold peak heart rate estimator
// A request that is not the last of a record is taken while idle and gives no result.
// A last request gives its result through a setup state with the two multipliers,
// a divide state on a shared restoring divide subtractor, and a done state.
// The block takes no request from setup until the done state loads its result, which
// waits while an earlier result is stalled. Synchronous reset restores the
// registers to their defaults and clears all record state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module threshold_peak_heart_rate (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tphr_pkg::SAMPLE_W-1:0]       req_sample,
   input  logic [tphr_pkg::TICK_W-1:0]         req_tick,
   input  logic                                req_last,
   // Result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tphr_pkg::BPM_W-1:0]          rsp_beats_per_minute,
   output logic                                rsp_valid_res,
   output logic [tphr_pkg::PEAK_W-1:0]         rsp_peaks_found,
   // Configuration port
   input  logic                                csr_wr_en,
   input  logic [tphr_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [tphr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SAMPLE_W = tphr_pkg::SAMPLE_W;
   localparam int TICK_W   = tphr_pkg::TICK_W;
   localparam int TMS_W    = tphr_pkg::TMS_W;
   localparam int BPM_W    = tphr_pkg::BPM_W;
   localparam int PEAK_W   = tphr_pkg::PEAK_W;
   localparam int NUM_W    = tphr_pkg::NUM_W;
   localparam int DEN_W    = tphr_pkg::DEN_W;
   localparam int STEP_W   = tphr_pkg::STEP_W;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SETUP  = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type             state_ff, state_in;

   logic [SAMPLE_W-1:0]   threshold_ff;
   logic [TMS_W-1:0]      tick_ms_ff;

   logic                  in_region_ff, in_region_in;
   logic [SAMPLE_W-1:0]   region_max_ff, region_max_in;
   logic [TICK_W-1:0]     region_tick_ff, region_tick_in;
   logic [TICK_W-1:0]     first_tick_ff, first_tick_in;
   logic [TICK_W-1:0]     latest_tick_ff, latest_tick_in;
   logic [PEAK_W-1:0]     peak_total_ff, peak_total_in;

   logic [PEAK_W-1:0]     count_ff, count_in;
   logic [TICK_W-1:0]     span_ff, span_in;
   logic                  valid_ff, valid_in;
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [DEN_W-1:0]      den_ff, den_in;
   logic [DEN_W-1:0]      rem_ff, rem_in;
   logic [NUM_W-1:0]      quot_ff, quot_in;
   logic [STEP_W-1:0]     step_ff, step_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BPM_W-1:0]      rsp_bpm_ff, rsp_bpm_in;
   logic                  rsp_vres_ff;
   logic [PEAK_W-1:0]     rsp_peaks_ff;

   logic                  req_accept;
   logic                  above;
   logic                  raise_peak;
   logic [SAMPLE_W-1:0]   step_max;
   logic [TICK_W-1:0]     step_tick;
   logic                  do_close;
   logic [TICK_W-1:0]     close_tick;
   logic                  room;
   logic [PEAK_W-1:0]     total_fin;
   logic [TICK_W-1:0]     first_fin;
   logic [TICK_W-1:0]     latest_fin;
   logic [DEN_W:0]        rem_shift;
   logic [DEN_W:0]        rem_diff;
   logic                  rsp_load;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= tphr_pkg::THRESHOLD_RESET;
         tick_ms_ff   <= tphr_pkg::TICK_MS_RESET;
      end else if (csr_wr_en) begin
         case (csr_addr)
            tphr_pkg::REG_THRESHOLD: threshold_ff <= csr_wdata;
            tphr_pkg::REG_TICK_MS:   tick_ms_ff   <= csr_wdata[TMS_W-1:0];
            default: ;
         endcase
      end
   end

   // Region tracking: open or raise a region on a sample above threshold, close it
   // on a sample at or below, and close a still open region on the last sample.
   always_comb begin
      above      = (req_sample > threshold_ff);
      raise_peak = !in_region_ff || (req_sample >= region_max_ff);
      step_max   = raise_peak ? req_sample : region_max_ff;
      step_tick  = raise_peak ? req_tick : region_tick_ff;
      do_close   = above ? req_last : in_region_ff;
      close_tick = above ? step_tick : region_tick_ff;
      room       = (peak_total_ff < PEAK_W'(tphr_pkg::MAX_PEAKS));

      total_fin  = peak_total_ff;
      first_fin  = first_tick_ff;
      latest_fin = latest_tick_ff;
      if (do_close && room) begin
         total_fin  = peak_total_ff + PEAK_W'(1);
         latest_fin = close_tick;
         if (peak_total_ff == '0) begin
            first_fin = close_tick;
         end
      end

      in_region_in   = in_region_ff;
      region_max_in  = region_max_ff;
      region_tick_in = region_tick_ff;
      first_tick_in  = first_tick_ff;
      latest_tick_in = latest_tick_ff;
      peak_total_in  = peak_total_ff;
      if (req_accept) begin
         if (req_last) begin
            in_region_in   = 1'b0;
            region_max_in  = '0;
            region_tick_in = '0;
            first_tick_in  = '0;
            latest_tick_in = '0;
            peak_total_in  = '0;
         end else begin
            in_region_in   = above;
            region_max_in  = above ? step_max : '0;
            region_tick_in = above ? step_tick : '0;
            first_tick_in  = first_fin;
            latest_tick_in = latest_fin;
            peak_total_in  = total_fin;
         end
      end
   end

   // One restoring divide step on the shared subtractor.
   always_comb begin
      rem_shift = {rem_ff, num_ff[NUM_W-1]};
      rem_diff  = rem_shift - {1'b0, den_ff};
   end

   // Sequencer: capture the record, form the operands, divide, then hand off.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      span_in  = span_ff;
      valid_in = valid_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      step_in  = step_ff;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_last) begin
               count_in = total_fin;
               span_in  = latest_fin - first_fin;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            num_in   = NUM_W'(tphr_pkg::MS_PER_MINUTE) * NUM_W'(count_ff - PEAK_W'(1));
            den_in   = DEN_W'(span_ff) * DEN_W'(tick_ms_ff);
            valid_in = (count_ff >= PEAK_W'(2)) && (span_ff != '0) && (tick_ms_ff != '0);
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!rem_diff[DEN_W]) begin
               rem_in = rem_diff[DEN_W-1:0];
            end else begin
               rem_in = rem_shift[DEN_W-1:0];
            end
            quot_in = {quot_ff[NUM_W-2:0], !rem_diff[DEN_W]};
            num_in  = {num_ff[NUM_W-2:0], 1'b0};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(NUM_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Saturated result, zero when the record is invalid.
   always_comb begin
      if (!valid_ff) begin
         rsp_bpm_in = '0;
      end else if (quot_ff > NUM_W'(tphr_pkg::BPM_LIMIT)) begin
         rsp_bpm_in = tphr_pkg::BPM_LIMIT;
      end else begin
         rsp_bpm_in = quot_ff[BPM_W-1:0];
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   // Control and record state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         in_region_ff   <= 1'b0;
         region_max_ff  <= '0;
         region_tick_ff <= '0;
         first_tick_ff  <= '0;
         latest_tick_ff <= '0;
         peak_total_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         in_region_ff   <= in_region_in;
         region_max_ff  <= region_max_in;
         region_tick_ff <= region_tick_in;
         first_tick_ff  <= first_tick_in;
         latest_tick_ff <= latest_tick_in;
         peak_total_ff  <= peak_total_in;
      end
   end

   // Divider datapath and result payload.
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      span_ff  <= span_in;
      valid_ff <= valid_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      step_ff  <= step_in;
      if (rsp_load) begin
         rsp_bpm_ff   <= rsp_bpm_in;
         rsp_vres_ff  <= valid_ff;
         rsp_peaks_ff <= count_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_beats_per_minute = rsp_bpm_ff;
   assign rsp_valid_res        = rsp_vres_ff;
   assign rsp_peaks_found      = rsp_peaks_ff;

`ifndef SYNTH
   // A last request starts the operand setup.
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last) |=> (state_ff == ST_SETUP))
      else $error("last request did not start the setup");

   // A last request leaves the record state cleared.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last) |=> (peak_total_ff == '0 && !in_region_ff))
      else $error("record state not cleared after last request");

   // The peak count never passes its limit.
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      peak_total_ff <= PEAK_W'(tphr_pkg::MAX_PEAKS))
      else $error("peak count above limit");

   // An invalid result reports zero beats per minute.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_vres_ff) |-> (rsp_bpm_ff == '0))
      else $error("invalid result with nonzero rate");

   // A finished divide that is not blocked shows a result next cycle.
   a_done_shows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall)) |=> rsp_valid_ff)
      else $error("finished divide produced no result");
`endif

endmodule

### tb/threshold_peak_heart_rate_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heart rate estimator testbench
// Sends records of timestamped samples through the request channel and checks
// every rate result against a behavioral estimator kept in step with each
// accepted request. Runs directed records first, then random pulse trains
// under several register settings and several idle and stall patterns.
// ----------------------------------------------------------------------------
module threshold_peak_heart_rate_tb;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_REPORTS  = 10;

   // One rate result as the block reports it.
   typedef struct packed {
      logic [tphr_pkg::BPM_W-1:0]  bpm;
      logic                        ok;
      logic [tphr_pkg::PEAK_W-1:0] peaks;
   } heart_rate_type;

   // Pulse tracking state of the record in progress.
   typedef struct packed {
      logic                          in_region;
      logic [tphr_pkg::SAMPLE_W-1:0] region_max;
      logic [tphr_pkg::TICK_W-1:0]   region_tick;
      logic [tphr_pkg::TICK_W-1:0]   first_tick;
      logic [tphr_pkg::TICK_W-1:0]   latest_tick;
      logic [tphr_pkg::PEAK_W-1:0]   peak_total;
   } pulse_state_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [tphr_pkg::SAMPLE_W-1:0]   req_sample;
   logic [tphr_pkg::TICK_W-1:0]     req_tick;
   logic                            req_last;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [tphr_pkg::BPM_W-1:0]      rsp_beats_per_minute;
   logic                            rsp_valid_res;
   logic [tphr_pkg::PEAK_W-1:0]     rsp_peaks_found;
   logic                            csr_wr_en;
   logic [tphr_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [tphr_pkg::CSR_DATA_W-1:0] csr_wdata;

   heart_rate_type                expected_rates[$];
   pulse_state_type               pulse;
   logic [tphr_pkg::SAMPLE_W-1:0] thr_shadow;
   logic [tphr_pkg::TMS_W-1:0]    tick_ms_shadow;
   logic [tphr_pkg::TICK_W-1:0]   tick_now;

   int unsigned idle_pct;
   int unsigned stall_pct;
   int unsigned items_sent;
   int unsigned results_seen;
   int unsigned mismatch_count;
   int unsigned reg_writes;
   int unsigned cycle_count;

   threshold_peak_heart_rate u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_sample           (req_sample),
      .req_tick             (req_tick),
      .req_last             (req_last),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_beats_per_minute (rsp_beats_per_minute),
      .rsp_valid_res        (rsp_valid_res),
      .rsp_peaks_found      (rsp_peaks_found),
      .csr_wr_en            (csr_wr_en),
      .csr_addr             (csr_addr),
      .csr_wdata            (csr_wdata)
   );

   // Free-running clock, 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // Random back-pressure on the result channel.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // ------------------------------------------------------------------------
   // Behavioral estimator
   // ------------------------------------------------------------------------

   // A finished region contributes its peak tick unless the peak list is full.
   task automatic close_pulse_region();
      if (pulse.in_region) begin
         pulse.in_region = 1'b0;
         if (pulse.peak_total < tphr_pkg::MAX_PEAKS) begin
            if (pulse.peak_total == 0)
               pulse.first_tick = pulse.region_tick;
            pulse.latest_tick = pulse.region_tick;
            pulse.peak_total++;
         end
         pulse.region_max  = '0;
         pulse.region_tick = '0;
      end
   endtask

   // Advance the estimator by one accepted request; a last request queues a rate.
   task automatic track_sample(input logic [tphr_pkg::SAMPLE_W-1:0] level,
                               input logic [tphr_pkg::TICK_W-1:0] stamp,
                               input logic is_last);
      heart_rate_type              rate;
      logic [tphr_pkg::TICK_W-1:0] span;
      logic [63:0]                 divisor;
      logic [63:0]                 quotient;
      if (level > thr_shadow) begin
         if (!pulse.in_region) begin
            pulse.in_region   = 1'b1;
            pulse.region_max  = level;
            pulse.region_tick = stamp;
         end else if (level >= pulse.region_max) begin
            // Ties move the peak to the later sample.
            pulse.region_max  = level;
            pulse.region_tick = stamp;
         end
      end else begin
         close_pulse_region();
      end
      if (is_last) begin
         close_pulse_region();
         span       = pulse.latest_tick - pulse.first_tick;
         divisor    = 64'(span) * 64'(tick_ms_shadow);
         rate.bpm   = '0;
         rate.ok    = 1'b0;
         rate.peaks = pulse.peak_total;
         if (pulse.peak_total >= 2 && divisor != 0) begin
            quotient = (64'(tphr_pkg::MS_PER_MINUTE) * 64'(pulse.peak_total - 1)) / divisor;
            rate.bpm = (quotient > 64'(tphr_pkg::BPM_LIMIT)) ? tphr_pkg::BPM_LIMIT :
                       quotient[tphr_pkg::BPM_W-1:0];
            rate.ok  = 1'b1;
         end
         expected_rates.push_back(rate);
         pulse = '0;
      end
   endtask

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      heart_rate_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_rates.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("Unexpected result: bpm %0d valid %0d peaks %0d",
                        rsp_beats_per_minute, rsp_valid_res, rsp_peaks_found);
         end else begin
            want = expected_rates.pop_front();
            if (rsp_beats_per_minute !== want.bpm || rsp_valid_res !== want.ok ||
                rsp_peaks_found !== want.peaks) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("Result %0d (bpm/valid/peaks): expected %0d/%0d/%0d, got %0d/%0d/%0d",
                           results_seen, want.bpm, want.ok, want.peaks,
                           rsp_beats_per_minute, rsp_valid_res, rsp_peaks_found);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // Send one request; entered and left at a falling edge, valid left high.
   task automatic send_sample(input logic [tphr_pkg::SAMPLE_W-1:0] level,
                              input logic [tphr_pkg::TICK_W-1:0] stamp,
                              input logic is_last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= level;
      req_tick   <= stamp;
      req_last   <= is_last;
      do @(posedge clock); while (req_stall);
      track_sample(level, stamp, is_last);
      items_sent++;
      @(negedge clock);
   endtask

   // Wait until every rate has come back, then let the divider settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_rates.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Register write; only called while the block is idle.
   task automatic write_reg(input logic [tphr_pkg::CSR_ADDR_W-1:0] index,
                            input logic [tphr_pkg::CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (index == tphr_pkg::REG_THRESHOLD)
         thr_shadow = value;
      else
         tick_ms_shadow = value[tphr_pkg::TMS_W-1:0];
      reg_writes++;
      @(negedge clock);
   endtask

   // Pick new register values, the extremes now and then.
   task automatic pick_registers();
      logic [tphr_pkg::CSR_DATA_W-1:0] thr;
      int unsigned                     tms;
      if ($urandom_range(7) == 0)
         thr = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      else
         thr = 16'($urandom_range(60000, 1000));
      case ($urandom_range(7))
         0:       tms = $urandom_range(1) ? 1000 : 1;
         1, 2, 3: tms = $urandom_range(20, 1);
         default: tms = $urandom_range(1000, 1);
      endcase
      write_reg(tphr_pkg::REG_THRESHOLD, thr);
      write_reg(tphr_pkg::REG_TICK_MS, tphr_pkg::CSR_DATA_W'(tms));
   endtask

   function automatic logic [tphr_pkg::SAMPLE_W-1:0] above_level();
      if (thr_shadow == 16'hFFFF)
         return 16'hFFFF;
      return tphr_pkg::SAMPLE_W'($urandom_range(65535, int'(thr_shadow) + 1));
   endfunction

   function automatic logic [tphr_pkg::SAMPLE_W-1:0] below_level();
      return tphr_pkg::SAMPLE_W'($urandom_range(int'(thr_shadow), 0));
   endfunction

   // One record: mostly pulse trains with random levels, some pure noise,
   // now and then a train long enough to overflow the peak list.
   task automatic send_record();
      logic [tphr_pkg::SAMPLE_W-1:0] levels[$];
      logic [tphr_pkg::SAMPLE_W-1:0] level;
      int unsigned                   kind, regions, step_max, r;
      int                            j;
      logic                          compact;
      kind = $urandom_range(19);
      case ($urandom_range(5))
         0:       step_max = 0;
         1:       step_max = 1;
         2:       step_max = 4;
         3:       step_max = 30;
         4:       step_max = 300;
         default: step_max = 100000;
      endcase
      if ($urandom_range(3) == 0)
         tick_now = $urandom;
      if (kind < 2) begin
         repeat ($urandom_range(12, 1)) levels.push_back(tphr_pkg::SAMPLE_W'($urandom));
      end else begin
         compact = (kind == 2);
         regions = compact ? $urandom_range(36, 33) : $urandom_range(8);
         repeat ($urandom_range(2)) levels.push_back(below_level());
         for (r = 0; r < regions; r++) begin
            level = above_level();
            repeat (compact ? 1 : $urandom_range(4, 1)) begin
               levels.push_back(level);
               if ($urandom_range(2) != 0)
                  level = above_level();
            end
            // The record may end while the last region is still open.
            if (r + 1 < regions || $urandom_range(2) != 0)
               repeat (compact ? 1 : $urandom_range(3, 1)) levels.push_back(below_level());
         end
         if (levels.size() == 0)
            levels.push_back(below_level());
      end
      for (j = 0; j < levels.size(); j++) begin
         tick_now += $urandom_range(step_max, 0);
         send_sample(levels[j], tick_now, j == levels.size() - 1);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Short records under the reset register values.
   task automatic test_directed_records();
      // No peak at all, then a single region closed by the last sample.
      send_sample(16'd0, 32'd5, 1'b1);
      send_sample(16'hFFFF, 32'd0, 1'b1);
      // Three peaks, a tie that moves the peak later, a sample exactly at
      // threshold closing a region, and a region still open at the end.
      send_sample(16'd40000, 32'd10, 1'b0);
      send_sample(16'd50000, 32'd11, 1'b0);
      send_sample(16'd50000, 32'd12, 1'b0);
      send_sample(16'd1000, 32'd13, 1'b0);
      send_sample(16'd60000, 32'd112, 1'b0);
      send_sample(16'd32768, 32'd113, 1'b0);
      send_sample(16'd32769, 32'd200, 1'b1);
      // Two peaks on the same tick give a zero span.
      send_sample(16'd40000, 32'd7, 1'b0);
      send_sample(16'd0, 32'd7, 1'b0);
      send_sample(16'd40000, 32'd7, 1'b1);
      // A one-tick span across the counter wrap saturates the rate.
      send_sample(16'd50000, 32'hFFFF_FFFF, 1'b0);
      send_sample(16'd10, 32'hFFFF_FFFF, 1'b0);
      send_sample(16'd50000, 32'd0, 1'b1);
      drain_results();
   endtask

   // Register extremes: lowest threshold with a slow tick, then the
   // highest threshold, which no sample can exceed.
   task automatic test_register_extremes();
      write_reg(tphr_pkg::REG_THRESHOLD, 16'd0);
      write_reg(tphr_pkg::REG_TICK_MS, 16'd1000);
      send_sample(16'd0, 32'd0, 1'b0);
      send_sample(16'd1, 32'd3, 1'b0);
      send_sample(16'd0, 32'd4, 1'b0);
      send_sample(16'd1, 32'd1003, 1'b1);
      drain_results();
      write_reg(tphr_pkg::REG_THRESHOLD, 16'hFFFF);
      write_reg(tphr_pkg::REG_TICK_MS, 16'd1);
      send_sample(16'hFFFF, 32'd1, 1'b0);
      send_sample(16'hFFFF, 32'd9, 1'b1);
      drain_results();
   endtask

   // Random records under one idle and stall pattern, with occasional
   // register changes between records.
   task automatic test_random_records(input int unsigned sender_idle,
                                      input int unsigned receiver_stall,
                                      input int unsigned item_count);
      int unsigned start_items;
      idle_pct    = sender_idle;
      stall_pct   = receiver_stall;
      start_items = items_sent;
      pick_registers();
      while (items_sent - start_items < item_count) begin
         send_record();
         if ($urandom_range(9) == 0) begin
            drain_results();
            pick_registers();
         end
      end
      drain_results();
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_sample     = '0;
      req_tick       = '0;
      req_last       = 1'b0;
      csr_wr_en      = 1'b0;
      csr_addr       = '0;
      csr_wdata      = '0;
      idle_pct       = 0;
      stall_pct      = 0;
      items_sent     = 0;
      reg_writes     = 0;
      tick_now       = '0;
      pulse          = '0;
      thr_shadow     = tphr_pkg::THRESHOLD_RESET;
      tick_ms_shadow = tphr_pkg::TICK_MS_RESET;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_records();
      test_register_extremes();
      test_random_records(0, 0, 200);
      test_random_records(49, 0, 200);
      test_random_records(0, 49, 200);
      test_random_records(19, 19, 200);

      $display("Sent %0d samples and checked %0d heart rate results", items_sent,
               results_seen);
      $display("Made %0d register writes across four idle and stall patterns", reg_writes);
      if (mismatch_count == 0 && expected_rates.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d bad results, %0d results never seen", mismatch_count,
                  expected_rates.size());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### threshold_peak_heart_rate.f
design/tphr_pkg.sv
design/threshold_peak_heart_rate.sv
tb/threshold_peak_heart_rate_tb.sv
